// ----- design/mfep_pkg.sv -----
// ---------------------------------------------------------------------------
// mfep_pkg
// Types and constants shared by the MIDI file event parser modules.
// ---------------------------------------------------------------------------
package mfep_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEAD, PH_HSKIP, PH_CHDR, PH_DELTA, PH_STATUS, PH_DATA,
    PH_MTYPE, PH_MLEN, PH_SYXLEN, PH_SKIP, PH_TEMPO, PH_DONE, PH_ERROR
  } phase_t;

  localparam logic [3:0] EV_DIVISION  = 4'd0;
  localparam logic [3:0] EV_NOTE_ON   = 4'd1;
  localparam logic [3:0] EV_NOTE_OFF  = 4'd2;
  localparam logic [3:0] EV_PROGRAM   = 4'd3;
  localparam logic [3:0] EV_VOLUME    = 4'd4;
  localparam logic [3:0] EV_BEND      = 4'd5;
  localparam logic [3:0] EV_TEMPO     = 4'd6;
  localparam logic [3:0] EV_TRACK_END = 4'd7;
  localparam logic [3:0] EV_ERROR     = 4'd8;

  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_ESCAPE  = 8'hF7;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;
  localparam logic [3:0] HI_CONTROL  = 4'hB;
  localparam logic [3:0] HI_BEND     = 4'hE;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] track;
    logic [31:0] tick;
    logic [7:0]  key;
    logic [7:0]  velocity;
    logic [23:0] value;
    logic        done;
    logic        last;
  } result_t;

  // Up to two results caused by one byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } pair_t;

  function automatic logic [7:0] head_tag(input logic [1:0] i);
    unique case (i)
      2'd0: head_tag = 8'h4D;
      2'd1: head_tag = 8'h54;
      2'd2: head_tag = 8'h68;
      default: head_tag = 8'h64;
    endcase
  endfunction

  function automatic logic [7:0] trk_tag(input logic [1:0] i);
    unique case (i)
      2'd0: trk_tag = 8'h4D;
      2'd1: trk_tag = 8'h54;
      2'd2: trk_tag = 8'h72;
      default: trk_tag = 8'h6B;
    endcase
  endfunction

endpackage

// ----- design/mfep_front.sv -----
// ---------------------------------------------------------------------------
// mfep_front
// Parses one byte per cycle and produces the results that byte causes.
// ---------------------------------------------------------------------------
module mfep_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    data_byte,
  input  logic          start_of_file,
  input  logic          end_of_file,
  output logic          res_valid,
  output mfep_pkg::pair_t res
);
  import mfep_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  fcount, fcount_next;
  logic [31:0] chunk_left, chunk_left_next;
  logic [15:0] tracks_left, tracks_left_next;
  logic [15:0] cur_track, cur_track_next;
  logic [31:0] tick, tick_next;
  logic [31:0] varlen, varlen_next;
  logic [7:0]  run_status, run_status_next;
  logic [7:0]  act_status, act_status_next;
  logic [7:0]  meta_type, meta_type_next;
  logic [31:0] skip_left, skip_left_next;
  logic [23:0] held, held_next;
  pair_t       out_next;

  function automatic logic [3:0] fcount_inc(input logic [3:0] v);
    fcount_inc = v + 4'd1;
  endfunction

  always_comb begin
    phase_t      ph;
    logic [3:0]  fc;
    logic [31:0] cl, vl, sk;
    logic [15:0] tl, ct;
    logic [7:0]  b, rs, as, hs;
    logic [31:0] tk;
    logic [23:0] hd;
    logic [7:0]  mt;
    logic [3:0]  hi;
    logic        need2, tfire;
    result_t     r;
    logic [1:0]  n;
    result_t     o0, o1;
    b  = data_byte;
    ph = phase; fc = fcount; cl = chunk_left; tl = tracks_left; ct = cur_track;
    tk = tick; vl = varlen; rs = run_status; as = act_status; mt = meta_type;
    sk = skip_left; hd = held; hi = 4'd0; need2 = 1'b0; tfire = 1'b0; hs = 8'd0;
    n = 2'd0; o0 = '0; o1 = '0; r = '0;
    if (in_valid) begin
      if (start_of_file) begin
        ph = PH_HEAD; fc = '0; cl = '0; tl = '0; ct = '0; tk = '0; vl = '0;
        rs = '0; as = '0; mt = '0; sk = '0; hd = '0;
      end
      if (ph != PH_IDLE && ph != PH_DONE && ph != PH_ERROR) begin
        unique case (ph)
          PH_HEAD: begin
            fc = fcount_inc(fc);
            if (fc == 4'd1 || fc == 4'd2 || fc == 4'd3 || fc == 4'd4) begin
              if (b != head_tag(2'(fc - 4'd1))) begin
                r = '0; r.kind = EV_ERROR; r.track = ct; o0 = r; n = 2'd1;
                ph = PH_ERROR;
              end
            end else if (fc >= 4'd5 && fc <= 4'd8) begin
              cl = {cl[23:0], b};
              if (fc == 4'd8 && cl < 32'd6) begin
                r = '0; r.kind = EV_ERROR; r.track = ct; o0 = r; n = 2'd1;
                ph = PH_ERROR;
              end
            end else if (fc == 4'd11 || fc == 4'd12) begin
              tl = {tl[7:0], b};
            end else if (fc == 4'd13) begin
              hd = {16'd0, b};
            end else if (fc == 4'd14) begin
              hd = {8'd0, hd[7:0], b};
              r = '0; r.kind = EV_DIVISION; r.value = hd; o0 = r; n = 2'd1;
              sk = cl - 32'd6;
              if (sk != 0) ph = PH_HSKIP;
              else begin
                fc = '0; ph = (tl == 0) ? PH_DONE : PH_CHDR;
              end
            end
          end
          PH_HSKIP: begin
            sk = sk - 32'd1;
            if (sk == 0) begin
              fc = '0; ph = (tl == 0) ? PH_DONE : PH_CHDR;
            end
          end
          PH_CHDR: begin
            fc = fcount_inc(fc);
            if (fc <= 4'd4 && fc != 4'd0) begin
              if (b != trk_tag(2'(fc - 4'd1))) begin
                r = '0; r.kind = EV_ERROR; r.track = ct; o0 = r; n = 2'd1;
                ph = PH_ERROR;
              end
            end else begin
              cl = {cl[23:0], b};
              if (fc >= 4'd8 || fc == 4'd0) begin
                tk = '0; rs = '0; as = '0; ph = PH_DELTA; vl = '0;
                if (cl == 0) tfire = 1'b1;
              end
            end
          end
          default: begin
            // Track body byte.
            unique case (ph)
              PH_DELTA: begin
                vl = {vl[24:0], b[6:0]};
                if (!b[7]) begin
                  tk = tk + vl; ph = PH_STATUS;
                end
              end
              PH_MTYPE: begin
                mt = b; vl = '0; ph = PH_MLEN;
              end
              PH_MLEN, PH_SYXLEN: begin
                vl = {vl[24:0], b[6:0]};
                if (!b[7]) begin
                  if (ph == PH_MLEN && mt == META_TEMPO && vl == 32'd3) begin
                    fc = '0; hd = '0; ph = PH_TEMPO;
                  end else if (vl == 0) begin
                    ph = PH_DELTA; vl = '0;
                  end else begin
                    sk = vl; ph = PH_SKIP;
                  end
                end
              end
              PH_SKIP: begin
                sk = sk - 32'd1;
                if (sk == 0) begin
                  ph = PH_DELTA; vl = '0;
                end
              end
              PH_TEMPO: begin
                hd = {hd[15:0], b};
                fc = fcount_inc(fc);
                if (fc >= 4'd3) begin
                  r = '0; r.kind = EV_TEMPO; r.track = ct; r.tick = tk; r.value = hd;
                  o0 = r; n = 2'd1; ph = PH_DELTA; vl = '0;
                end
              end
              PH_STATUS, PH_DATA: begin
                if (ph == PH_STATUS) fc = '0;
                if (ph == PH_STATUS && b[7]) begin
                  as = b;
                  if (b == ST_META) ph = PH_MTYPE;
                  else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                    vl = '0; ph = PH_SYXLEN;
                  end else begin
                    rs = b; ph = PH_DATA;
                  end
                end else begin
                  if (ph == PH_STATUS) as = rs;
                  hi = as[7:4];
                  need2 = !(hi == HI_PROGRAM || hi == HI_PRESSURE);
                  if (fc == 4'd0) hd = {16'd0, b};
                  fc = fcount_inc(fc);
                  if (need2 && fc < 4'd2) ph = PH_DATA;
                  else begin
                    hs = hd[7:0];
                    r = '0; r.track = ct; r.tick = tk;
                    priority if (hi == HI_NOTE_ON) begin
                      r.kind = EV_NOTE_ON; r.key = hs; r.velocity = b; n = 2'd1;
                    end else if (hi == HI_NOTE_OFF) begin
                      r.kind = EV_NOTE_OFF; r.key = hs; r.velocity = b; n = 2'd1;
                    end else if (hi == HI_PROGRAM) begin
                      r.kind = EV_PROGRAM; r.value = {16'd0, hs}; n = 2'd1;
                    end else if (hi == HI_CONTROL) begin
                      if (hs == 8'd7) begin
                        r.kind = EV_VOLUME; r.value = {16'd0, b}; n = 2'd1;
                      end
                    end else if (hi == HI_BEND) begin
                      r.kind = EV_BEND;
                      r.value = {9'd0, b, 7'd0} | {16'd0, hs}; n = 2'd1;
                    end
                    o0 = r; ph = PH_DELTA; vl = '0;
                  end
                end
              end
              default: ;
            endcase
            cl = cl - 32'd1;
            if (cl == 0) tfire = 1'b1;
          end
        endcase
        if (tfire) begin
          r = '0; r.kind = EV_TRACK_END; r.track = ct; r.tick = tk;
          r.done = (tl == 16'd1);
          if (n == 2'd0) o0 = r; else o1 = r;
          n = n + 2'd1;
          tl = tl - 16'd1; ct = ct + 16'd1; fc = '0;
          ph = (tl == 0) ? PH_DONE : PH_CHDR;
        end
        if (end_of_file && ph != PH_DONE && ph != PH_ERROR) begin
          if (n == 2'd2 && o1.kind == EV_TRACK_END) n = 2'd1;
          else if (n == 2'd1 && o0.kind == EV_TRACK_END) n = 2'd0;
          r = '0; r.kind = EV_ERROR; r.track = ct;
          if (n == 2'd0) o0 = r; else o1 = r;
          n = n + 2'd1; ph = PH_ERROR;
        end
      end
      if (n == 2'd1) o0.last = 1'b1;
      if (n == 2'd2) o1.last = 1'b1;
    end
    phase_next = ph; fcount_next = fc; chunk_left_next = cl; tracks_left_next = tl;
    cur_track_next = ct; tick_next = tk; varlen_next = vl; run_status_next = rs;
    act_status_next = as; meta_type_next = mt; skip_left_next = sk; held_next = hd;
    out_next.count = n; out_next.r0 = o0; out_next.r1 = o1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; fcount <= '0; chunk_left <= '0; tracks_left <= '0;
      cur_track <= '0; tick <= '0; varlen <= '0; run_status <= '0;
      act_status <= '0; meta_type <= '0; skip_left <= '0; held <= '0;
      res_valid <= 1'b0;
    end else begin
      phase <= phase_next; fcount <= fcount_next; chunk_left <= chunk_left_next;
      tracks_left <= tracks_left_next; cur_track <= cur_track_next;
      tick <= tick_next; varlen <= varlen_next; run_status <= run_status_next;
      act_status <= act_status_next; meta_type <= meta_type_next;
      skip_left <= skip_left_next; held <= held_next;
      res_valid <= in_valid && (out_next.count != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    res <= out_next;
  end
endmodule

// ----- design/mfep_queue.sv -----
// ---------------------------------------------------------------------------
// mfep_queue
// Result queue: takes up to two results a cycle, hands out one a cycle on pop.
// ---------------------------------------------------------------------------
module mfep_queue #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  input  mfep_pkg::pair_t   wr_data,
  output logic              almost_full,
  input  logic              pop,
  output logic              empty,
  output mfep_pkg::result_t head
);
  import mfep_pkg::*;

  localparam int AW = $clog2(DEPTH);

  result_t        mem [DEPTH];
  logic [AW-1:0]  rd_ptr, wr_ptr;
  logic [AW:0]    count, count_next;
  logic           do_pop;
  logic [AW:0]    n_wr;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign n_wr   = wr_valid ? (AW+1)'(wr_data.count) : '0;
  assign count_next = count + n_wr - (AW+1)'(do_pop);
  // Room kept for the two results of the byte in flight plus two more.
  assign almost_full = (count > (AW+1)'(DEPTH - 4));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0; wr_ptr <= '0; count <= '0;
    end else begin
      rd_ptr <= rd_ptr + AW'(do_pop);
      wr_ptr <= wr_ptr + n_wr[AW-1:0];
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_data.count != 2'd0) mem[wr_ptr] <= wr_data.r0;
    if (wr_valid && wr_data.count == 2'd2) mem[wr_ptr + AW'(1)] <= wr_data.r1;
  end
endmodule

// ----- design/midi_file_event_parser_top.sv -----
// ---------------------------------------------------------------------------
// midi_file_event_parser_top
// Standard MIDI file parser: bytes in, note, control and tempo events out.
// ---------------------------------------------------------------------------
// One file byte is taken per cycle while full is low; the parser state
// machine updates in that cycle and the results of that byte (at most two)
// enter an eight-entry queue in the cycle after. Results leave one per cycle
// while pop is high, so throughput is one byte per cycle except where a byte
// makes two results and the consumer drains at one a cycle; full rises when
// the queue is nearly full.
module midi_file_event_parser_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  input  logic        end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  event_kind,
  output logic [15:0] track_number,
  output logic [31:0] event_tick,
  output logic [7:0]  note_key,
  output logic [7:0]  note_velocity,
  output logic [23:0] event_value,
  output logic        file_done,
  output logic        last_of_run
);
  import mfep_pkg::*;

  logic    res_valid;
  pair_t   res;
  result_t head;

  mfep_front u_front (
    .clk, .rst, .in_valid(push && !full), .data_byte, .start_of_file,
    .end_of_file, .res_valid, .res
  );

  mfep_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .wr_valid(res_valid), .wr_data(res), .almost_full(full),
    .pop, .empty, .head
  );

  assign event_kind    = head.kind;
  assign track_number  = head.track;
  assign event_tick    = head.tick;
  assign note_key      = head.key;
  assign note_velocity = head.velocity;
  assign event_value   = head.value;
  assign file_done     = head.done;
  assign last_of_run   = head.last;
endmodule

// ----- design/mfep_checker.sv -----
// ---------------------------------------------------------------------------
// mfep_checker
// Port-level checks on the MIDI file event parser.
// ---------------------------------------------------------------------------
module mfep_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  event_kind,
  input logic [15:0] track_number,
  input logic [31:0] event_tick,
  input logic        file_done
);
  import mfep_pkg::*;

  // A waiting result holds while it is not taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(event_tick)))
    else $error("waiting result changed");

  // Results of an item reach the queue in the cycle after it is taken, so an
  // empty queue stays empty when no item was taken this cycle or the last.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (empty && !(push && !full) && !$past(push && !full)) |=> empty)
    else $error("result appeared without input");

  // Only a track end can carry the done flag.
  a_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && file_done) |-> (event_kind == EV_TRACK_END))
    else $error("done flag on wrong kind");

  // Division results belong to no track and have no tick.
  a_div: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_kind == EV_DIVISION) |-> (track_number == 16'd0 && event_tick == 32'd0))
    else $error("bad division result");
endmodule

bind midi_file_event_parser_top mfep_checker u_checker (
  .clk, .rst, .push, .full, .empty, .pop, .event_kind, .track_number,
  .event_tick, .file_done
);

// ----- tb/tb_midi_file_event_parser_top.sv -----
// ---------------------------------------------------------------------------
// tb_midi_file_event_parser_top
// Self-checking bench for the MIDI file event parser.
// ---------------------------------------------------------------------------
// Builds MIDI files byte by byte: a directed set of corner-case files, then
// random well-formed files with random events plus corrupted and cut-off
// files. A behavioural parser predicts every result, and a scoreboard checks
// each popped result against the oldest prediction.
module tb_midi_file_event_parser_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mfep_pkg::*;

  class event_scoreboard;
    result_t pending[$];
    int errors;
    int checked;

    function void note_result(result_t r);
      pending = {pending, r};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d", $time, got.kind);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: mismatch expected kind=%0d trk=%0d tick=%0h key=%0h vel=%0h",
                 $time, want.kind, want.track, want.tick, want.key, want.velocity);
        $display("    expected val=%0h done=%0b last=%0b",
                 want.value, want.done, want.last);
        $display("%0t:          actual kind=%0d trk=%0d tick=%0h key=%0h vel=%0h",
                 $time, got.kind, got.track, got.tick, got.key, got.velocity);
        $display("    actual val=%0h done=%0b last=%0b",
                 got.value, got.done, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic [7:0]  data_byte = 0;
  logic        start_of_file = 0;
  logic        end_of_file = 0;
  logic        pop = 0;
  logic        full, empty, file_done, last_of_run;
  logic [3:0]  event_kind;
  logic [15:0] track_number;
  logic [31:0] event_tick;
  logic [7:0]  note_key, note_velocity;
  logic [23:0] event_value;

  midi_file_event_parser_top dut (.*);

  always #4 clk = ~clk;

  event_scoreboard sb = new();

  // Predictor state.
  phase_t      ph = PH_IDLE;
  logic [3:0]  fcount;
  logic [31:0] chunk_left, tick_acc, vlen, skip_left;
  logic [15:0] tracks_left, cur_track;
  logic [7:0]  run_status, act_status, meta_kind;
  logic [23:0] held;
  result_t     step_out[$];

  bit calm = 0;
  int bytes_sent = 0;
  int files_sent = 0;

  function automatic void emit(logic [3:0] kind, logic [31:0] tick, logic [7:0] key,
                               logic [7:0] vel, logic [23:0] val, logic done);
    result_t r;
    if (step_out.size() >= 2) return;
    r.kind = kind; r.track = (kind == EV_DIVISION) ? 16'd0 : cur_track;
    r.tick = tick; r.key = key; r.velocity = vel; r.value = val;
    r.done = done; r.last = 0;
    step_out = {step_out, r};
  endfunction

  function automatic void go_error();
    emit(EV_ERROR, '0, '0, '0, '0, 1'b0);
    ph = PH_ERROR;
  endfunction

  function automatic void begin_delta();
    ph = PH_DELTA; vlen = 0;
  endfunction

  function automatic void close_track();
    emit(EV_TRACK_END, tick_acc, '0, '0, '0, tracks_left == 1);
    tracks_left--; cur_track++; fcount = 0;
    ph = (tracks_left == 0) ? PH_DONE : PH_CHDR;
  endfunction

  function automatic void channel_data(logic [7:0] b);
    logic [3:0] hi;
    int need;
    hi = act_status[7:4];
    need = (hi == HI_PROGRAM || hi == HI_PRESSURE) ? 1 : 2;
    if (fcount == 0) held = {16'd0, b};
    fcount++;
    if (fcount < need) begin
      ph = PH_DATA;
      return;
    end
    case (hi)
      HI_NOTE_ON:  emit(EV_NOTE_ON, tick_acc, held[7:0], b, '0, 1'b0);
      HI_NOTE_OFF: emit(EV_NOTE_OFF, tick_acc, held[7:0], b, '0, 1'b0);
      HI_PROGRAM:  emit(EV_PROGRAM, tick_acc, '0, '0, {16'd0, held[7:0]}, 1'b0);
      HI_CONTROL:  if (held[7:0] == 8'd7) emit(EV_VOLUME, tick_acc, '0, '0, {16'd0, b}, 1'b0);
      HI_BEND:     emit(EV_BEND, tick_acc, '0, '0, {16'd0, held[7:0]} | (24'(b) << 7), 1'b0);
      default: ;
    endcase
    begin_delta();
  endfunction

  function automatic void in_track(logic [7:0] b);
    case (ph)
      PH_DELTA: begin
        vlen = (vlen << 7) | b[6:0];
        if (!b[7]) begin
          tick_acc += vlen; ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        fcount = 0;
        if (b[7]) begin
          act_status = b;
          if (b == ST_META) ph = PH_MTYPE;
          else if (b == ST_SYSEX || b == ST_ESCAPE) begin
            vlen = 0; ph = PH_SYXLEN;
          end else begin
            run_status = b; ph = PH_DATA;
          end
        end else begin
          act_status = run_status;
          channel_data(b);
        end
      end
      PH_DATA: channel_data(b);
      PH_MTYPE: begin
        meta_kind = b; vlen = 0; ph = PH_MLEN;
      end
      PH_MLEN, PH_SYXLEN: begin
        vlen = (vlen << 7) | b[6:0];
        if (!b[7]) begin
          if (ph == PH_MLEN && meta_kind == META_TEMPO && vlen == 3) begin
            fcount = 0; held = 0; ph = PH_TEMPO;
          end else if (vlen == 0) begin_delta();
          else begin
            skip_left = vlen; ph = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        skip_left--;
        if (skip_left == 0) begin_delta();
      end
      PH_TEMPO: begin
        held = {held[15:0], b};
        fcount++;
        if (fcount >= 3) begin
          emit(EV_TEMPO, tick_acc, '0, '0, held, 1'b0);
          begin_delta();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic sof, logic eof);
    logic [3:0] idx;
    step_out.delete();
    if (sof) begin
      ph = PH_HEAD; fcount = 0; chunk_left = 0; tracks_left = 0; cur_track = 0;
      tick_acc = 0; vlen = 0; run_status = 0; act_status = 0; meta_kind = 0;
      skip_left = 0; held = 0;
    end
    if (ph == PH_IDLE || ph == PH_DONE || ph == PH_ERROR) return;
    idx = fcount;
    if (ph == PH_HEAD) begin
      fcount = idx + 4'd1;
      if (idx < 4) begin
        if (b != head_tag(idx[1:0])) go_error();
      end else if (idx < 8) begin
        chunk_left = (chunk_left << 8) | b;
        if (idx == 7 && chunk_left < 6) go_error();
      end else if (idx == 10 || idx == 11) tracks_left = {tracks_left[7:0], b};
      else if (idx == 12) held = {16'd0, b};
      else if (idx == 13) begin
        held = {8'd0, held[7:0], b};
        emit(EV_DIVISION, '0, '0, '0, held, 1'b0);
        skip_left = chunk_left - 6;
        if (skip_left != 0) ph = PH_HSKIP;
        else begin
          fcount = 0; ph = (tracks_left == 0) ? PH_DONE : PH_CHDR;
        end
      end
    end else if (ph == PH_HSKIP) begin
      skip_left--;
      if (skip_left == 0) begin
        fcount = 0; ph = (tracks_left == 0) ? PH_DONE : PH_CHDR;
      end
    end else if (ph == PH_CHDR) begin
      fcount = idx + 4'd1;
      if (idx < 4) begin
        if (b != trk_tag(idx[1:0])) go_error();
      end else begin
        chunk_left = (chunk_left << 8) | b;
        if (idx >= 7) begin
          tick_acc = 0; run_status = 0; act_status = 0;
          begin_delta();
          if (chunk_left == 0) close_track();
        end
      end
    end else begin
      in_track(b);
      chunk_left--;
      if (chunk_left == 0) close_track();
    end
    if (eof && ph != PH_DONE && ph != PH_ERROR) begin
      if (step_out.size() > 0 && step_out[$].kind == EV_TRACK_END) void'(step_out.pop_back());
      go_error();
    end
    if (step_out.size() > 0) step_out[$].last = 1;
  endfunction

  task automatic send_byte(logic [7:0] b, logic sof, logic eof);
    while (!calm && $urandom_range(99) < 28) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1; data_byte <= b; start_of_file <= sof; end_of_file <= eof;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(b, sof, eof);
    foreach (step_out[i]) sb.note_result(step_out[i]);
    bytes_sent++;
  endtask

  task automatic send_file(byte unsigned f[$]);
    foreach (f[i]) send_byte(f[i], i == 0, i == f.size() - 1);
    files_sent++;
  endtask

  // Result side: random pop, check on each accepted edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty)
        sb.check_result({event_kind, track_number, event_tick, note_key, note_velocity,
                         event_value, file_done, last_of_run});
      pop <= calm || ($urandom_range(99) >= 28);
    end
  end

  // File building helpers.
  function automatic void add_byte(ref byte unsigned q[$], input byte unsigned v);
    q = {q, v};
  endfunction

  function automatic void add_varlen(ref byte unsigned q[$], input logic [31:0] v,
                                     input int extra);
    byte unsigned grp[$];
    do begin
      grp.push_front({1'b0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
    repeat (extra) grp.push_front(8'd0);
    foreach (grp[i]) add_byte(q, grp[i] | ((i != grp.size() - 1) ? 8'h80 : 8'h00));
  endfunction

  function automatic void add_header(ref byte unsigned q[$], input logic [31:0] hlen,
                                     input logic [15:0] ntrk, input logic [15:0] div);
    add_byte(q, "M"); add_byte(q, "T"); add_byte(q, "h"); add_byte(q, "d");
    for (int i = 3; i >= 0; i--) add_byte(q, hlen[8*i +: 8]);
    add_byte(q, 8'd0); add_byte(q, 8'd1);
    add_byte(q, ntrk[15:8]); add_byte(q, ntrk[7:0]);
    add_byte(q, div[15:8]); add_byte(q, div[7:0]);
    for (int i = 6; i < hlen; i++) add_byte(q, 8'($urandom));
  endfunction

  function automatic void add_track(ref byte unsigned q[$], input byte unsigned body[$],
                                    input int len_fix);
    logic [31:0] n;
    n = body.size() + len_fix;
    add_byte(q, "M"); add_byte(q, "T"); add_byte(q, "r"); add_byte(q, "k");
    for (int i = 3; i >= 0; i--) add_byte(q, n[8*i +: 8]);
    foreach (body[i]) add_byte(q, body[i]);
  endfunction

  function automatic void add_event(ref byte unsigned q[$]);
    int sel;
    logic [31:0] d;
    int n;
    sel = $urandom_range(13);
    case ($urandom_range(3))
      0: d = 0;
      1: d = $urandom_range(127);
      2: d = $urandom_range(20000);
      default: d = $urandom;
    endcase
    add_varlen(q, d, ($urandom_range(9) == 0) ? 1 : 0);
    case (sel)
      0, 1: begin
        add_byte(q, {4'h9, 4'($urandom)}); add_byte(q, 8'($urandom));
        add_byte(q, 8'($urandom));
      end
      2: begin
        add_byte(q, {4'h8, 4'($urandom)}); add_byte(q, 8'($urandom));
        add_byte(q, 8'($urandom));
      end
      3: begin
        add_byte(q, {4'hC, 4'($urandom)}); add_byte(q, 8'($urandom));
      end
      4: begin
        add_byte(q, {4'hB, 4'($urandom)});
        add_byte(q, $urandom_range(1) ? 8'd7 : 8'($urandom)); add_byte(q, 8'($urandom));
      end
      5: begin
        add_byte(q, {4'hE, 4'($urandom)}); add_byte(q, 8'($urandom));
        add_byte(q, 8'($urandom));
      end
      6: begin
        add_byte(q, {4'hD, 4'($urandom)}); add_byte(q, 8'($urandom));
      end
      7, 8: begin
        // Running-status data, or a lone data byte if none is active.
        add_byte(q, 8'($urandom_range(127))); add_byte(q, 8'($urandom));
      end
      9: begin
        add_byte(q, ST_META); add_byte(q, META_TEMPO); add_byte(q, 8'd3);
        add_byte(q, 8'($urandom)); add_byte(q, 8'($urandom)); add_byte(q, 8'($urandom));
      end
      10: begin
        add_byte(q, ST_META); add_byte(q, $urandom_range(1) ? 8'($urandom) : META_TEMPO);
        n = $urandom_range(5);
        add_varlen(q, n, 0);
        repeat (n) add_byte(q, 8'($urandom));
      end
      11: begin
        add_byte(q, $urandom_range(1) ? ST_SYSEX : ST_ESCAPE);
        n = $urandom_range(4);
        add_varlen(q, n, 0);
        repeat (n) add_byte(q, 8'($urandom));
      end
      12: begin
        add_byte(q, 8'($urandom_range(8'hF1, 8'hFE))); add_byte(q, 8'($urandom));
        add_byte(q, 8'($urandom));
      end
      default: begin
        add_byte(q, {4'h9, 4'($urandom)}); add_byte(q, 8'($urandom)); add_byte(q, 8'd0);
      end
    endcase
  endfunction

  task automatic random_file();
    byte unsigned f[$];
    byte unsigned body[$];
    int ntrk, fix, mode;
    mode = $urandom_range(19);
    ntrk = $urandom_range(1, 3);
    add_header(f, ($urandom_range(5) == 0) ? $urandom_range(6, 9) : 6, ntrk, $urandom);
    for (int t = 0; t < ntrk; t++) begin
      body.delete();
      repeat ($urandom_range(1, 6)) add_event(body);
      if ($urandom_range(1)) begin
        add_byte(body, 8'd0); add_byte(body, ST_META); add_byte(body, 8'h2F);
        add_byte(body, 8'd0);
      end
      fix = (mode == 1) ? -int'($urandom_range(1, 3)) : 0;
      if (fix + body.size() < 0) fix = 0;
      add_track(f, body, fix);
    end
    if (mode == 2) f[$urandom_range(f.size() - 1)] = 8'($urandom);  // corrupted byte
    if (mode == 3) f = f[0:$urandom_range(f.size() - 1)];            // file cut short
    if (mode == 4) repeat ($urandom_range(1, 4)) add_byte(f, 8'($urandom));
    send_file(f);
  endtask

  initial begin
    byte unsigned f[$];
    byte unsigned body[$];
    repeat (3) @(posedge clk);
    rst <= 0;
    // Bytes before any start are ignored.
    send_byte(8'hFF, 0, 0);
    send_byte(8'h00, 0, 1);
    // Bad header tag, short header, zero tracks.
    f = '{"M", "X"}; send_file(f);
    f.delete(); add_header(f, 6, 0, 16'hFFFF); f[7] = 5; send_file(f);
    f.delete(); add_header(f, 6, 0, 16'h0000); send_file(f);
    // Extra header bytes, one empty track, then a track with every event type.
    f.delete(); add_header(f, 8, 2, 16'h8000);
    add_track(f, body, 0);
    body = '{8'h00, 8'h95, 8'h7F, 8'hFF, 8'h7F, 8'h00, 8'h01,
             8'h8F, 8'h00, 8'h00, 8'h00, 8'hC3, 8'h7F, 8'h00, 8'hB0, 8'h07, 8'hFF,
             8'h00, 8'hE2, 8'h7F, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h51,
             8'h03, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hF0, 8'h01, 8'hF7, 8'h00, 8'hF3,
             8'h01, 8'h02, 8'h00, 8'h05, 8'h06};
    add_track(f, body, 0);
    add_byte(f, 8'hAA);
    send_file(f);
    // Lone data byte with no status, bad track tag, cut-off event, early end.
    f.delete(); add_header(f, 6, 1, 16'h0060);
    body = '{8'h00, 8'h40, 8'h40, 8'h00, 8'h90}; add_track(f, body, 0); send_file(f);
    f.delete(); add_header(f, 6, 1, 16'h0001); add_byte(f, "M"); add_byte(f, "t");
    send_file(f);
    f.delete(); add_header(f, 6, 1, 16'h0001);
    body = '{8'h00, 8'h90, 8'h3C, 8'h64}; add_track(f, body, -1); send_file(f);
    f.delete(); add_header(f, 6, 2, 16'h0001);
    body = '{8'h00, 8'hC0, 8'h05}; add_track(f, body, 0); send_file(f);

    // Random part: a calm stretch with no idling first, then random idling.
    while (bytes_sent < 600) begin
      calm = (files_sent >= 8 && files_sent < 12);
      random_file();
    end
    calm = 0;
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d files, %0d bytes, %0d results checked.",
             files_sent, bytes_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out.");
    $display("CHECK FAILED");
    $finish;
  end
endmodule
